### rtl/core/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg: per-CPU page allocator shared definitions
// Sizes, register indexes, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int MAX_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W  = 32;
  localparam int CPU_IN_W = 3;
  localparam int CPU_W   = $clog2(NUM_CPUS);
  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int OFS_W   = $clog2(PAGE_BYTES);
  localparam int APG_W   = ADDR_W - OFS_W;
  localparam int LINK_W  = PAGE_W + 1;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_START = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP  = 1'd1;

  localparam logic [ADDR_W-1:0] START_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] STOP_RESET  = 32'h8800_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FREE,
    S_PICK,
    S_LINK
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [PAGE_W-1:0] page;
  } link_t;

  typedef struct packed {
    logic capture;
    logic free_commit;
    logic pick_read;
    logic empty_done;
    logic pop_commit;
  } cmd_t;

  typedef struct packed {
    logic any_avail;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/per_cpu_page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator: per-CPU LIFO free-list page allocator
// Keeps one LIFO list of free pages per CPU: head registers plus a
// next-link RAM indexed by page number.
//
// Channels: cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// region_start (index 0) and region_stop (index 1); cfg_ready is always
// high. The request channel (in_valid/in_ready) carries kind, cpu and
// page_addr; the result channel (out_valid/out_ready) returns status,
// alloc_addr and source_cpu, one beat per request.
// Sequencing: requests are taken one at a time. A free, and an allocate that
// finds every list empty, raise out_valid once the free or pick state has
// loaded the output register. An allocate that finds a page passes list pick,
// then the registered link RAM read, before it raises out_valid.
// Reset: all lists empty, region registers at their defaults; the link RAM
// needs no clearing. When the receiver stalls, the finished result holds in
// the output register and the next request is accepted, but its result
// waits until the held beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcpa_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pcpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [pcpa_pkg::CPU_IN_W-1:0]  cpu,
  input  logic [pcpa_pkg::ADDR_W-1:0]    page_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [pcpa_pkg::ADDR_W-1:0]    alloc_addr,
  output logic [pcpa_pkg::CPU_IN_W-1:0]  source_cpu
);
  import pcpa_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  pcpa_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .cpu        (cpu),
    .page_addr  (page_addr),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .alloc_addr (alloc_addr),
    .source_cpu (source_cpu)
  );

endmodule

`default_nettype wire

### rtl/core/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// pcpa_ctrl: allocator sequencer
// Accepts one request at a time and steps the datapath through free,
// list pick, link read and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            kind,
  output logic            in_ready,
  input  pcpa_pkg::stat_t st,
  output pcpa_pkg::cmd_t  cmd
);
  import pcpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (kind == KIND_FREE) ? S_FREE : S_PICK;
        end
      end
      S_FREE: begin
        if (st.out_free) begin
          cmd.free_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_PICK: begin
        if (st.any_avail) begin
          cmd.pick_read = 1'b1;
          state_next    = S_LINK;
        end else if (st.out_free) begin
          cmd.empty_done = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_LINK: begin
        if (st.out_free) begin
          cmd.pop_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_capture_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state != S_IDLE)
    else $error("request captured but sequencer stayed idle");

  a_link_after_pick: assert property (@(posedge clk) disable iff (rst)
    state == S_LINK |-> $past(state == S_PICK) || $past(state == S_LINK))
    else $error("link state entered without a list pick");

endmodule

`default_nettype wire

### rtl/core/pcpa_dpath.sv
// ----------------------------------------------------------------------------
// pcpa_dpath: allocator datapath
// Region registers, list heads, next-link memory, address checks and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [pcpa_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [pcpa_pkg::ADDR_W-1:0]       cfg_data,
  input  logic                              kind,
  input  logic [pcpa_pkg::CPU_IN_W-1:0]     cpu,
  input  logic [pcpa_pkg::ADDR_W-1:0]       page_addr,
  input  pcpa_pkg::cmd_t                    cmd,
  output pcpa_pkg::stat_t                   st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [pcpa_pkg::ADDR_W-1:0]       alloc_addr,
  output logic [pcpa_pkg::CPU_IN_W-1:0]     source_cpu
);
  import pcpa_pkg::*;

  logic [ADDR_W-1:0] region_start;
  logic [ADDR_W-1:0] region_stop;

  logic              kind_r;
  logic [CPU_W-1:0]  cpu_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CPU_W-1:0]  sel_r;
  logic [PAGE_W-1:0] page_r;

  link_t             head [NUM_CPUS];
  logic [NUM_CPUS-1:0] hv;
  logic [CPU_W-1:0]  pick_sel;
  logic              other_found;
  logic [CPU_W-1:0]  other_sel;
  logic [CPU_W-1:0]  head_ra;
  link_t             head_rd;

  logic [APG_W:0]    base_pg;
  logic [APG_W:0]    diff;
  logic              free_ok;
  logic [PAGE_W-1:0] free_page;
  logic [APG_W-1:0]  alloc_pg;

  logic [LINK_W-1:0] ram_rdata;
  link_t             link_rd;
  logic              load;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= START_RESET;
      region_stop  <= STOP_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START) begin
        region_start <= cfg_data;
      end
      if (cfg_index == REG_STOP) begin
        region_stop <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind;
      cpu_r  <= CPU_W'(32'(cpu) % NUM_CPUS);
      addr_r <= page_addr;
    end
    if (cmd.pick_read) begin
      sel_r  <= pick_sel;
      page_r <= head_rd.page;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      hv[i] = head[i].valid;
    end
  end

  always_comb begin
    other_found = 1'b0;
    other_sel   = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (hv[i] && (CPU_W'(i) != cpu_r)) begin
        other_found = 1'b1;
        other_sel   = CPU_W'(i);
      end
    end
  end

  assign pick_sel     = hv[cpu_r] ? cpu_r : other_sel;
  assign st.any_avail = hv[cpu_r] || other_found;
  assign st.out_free  = !out_valid || out_ready;

  assign head_ra = (kind_r == KIND_FREE) ? cpu_r : pick_sel;
  assign head_rd = head[head_ra];

  assign base_pg   = {1'b0, region_start[ADDR_W-1:OFS_W]}
                   + (APG_W+1)'(|region_start[OFS_W-1:0]);
  assign diff      = {1'b0, addr_r[ADDR_W-1:OFS_W]} - base_pg;
  assign free_page = diff[PAGE_W-1:0];
  assign free_ok   = (addr_r[OFS_W-1:0] == '0)
                  && (addr_r >= region_start)
                  && (addr_r < region_stop)
                  && ({1'b0, addr_r[ADDR_W-1:OFS_W]} >= base_pg)
                  && (diff < (APG_W+1)'(MAX_PAGES));

  assign link_rd  = link_t'(ram_rdata);
  assign alloc_pg = base_pg[APG_W-1:0] + APG_W'(page_r);

  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.free_commit && free_ok),
    .waddr (free_page),
    .wdata (head_rd),
    .re    (cmd.pick_read),
    .raddr (head_rd.page),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head[i] <= '0;
      end
    end else if (cmd.free_commit && free_ok) begin
      head[cpu_r] <= '{valid: 1'b1, page: free_page};
    end else if (cmd.pop_commit) begin
      head[sel_r] <= link_rd;
    end
  end

  assign load = cmd.free_commit || cmd.empty_done || cmd.pop_commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.free_commit) begin
      status     <= free_ok ? ST_OK : ST_BAD;
      alloc_addr <= '0;
      source_cpu <= CPU_IN_W'(cpu_r);
    end else if (cmd.empty_done) begin
      status     <= ST_EMPTY;
      alloc_addr <= '0;
      source_cpu <= CPU_IN_W'(cpu_r);
    end else if (cmd.pop_commit) begin
      status     <= ST_OK;
      alloc_addr <= {alloc_pg, OFS_W'(0)};
      source_cpu <= CPU_IN_W'(sel_r);
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    load |-> !out_valid || out_ready)
    else $error("result loaded over an untaken beat");

  a_push_sets_head: assert property (@(posedge clk) disable iff (rst)
    cmd.free_commit && free_ok |=> head[$past(cpu_r)].valid)
    else $error("good free left its list empty");

endmodule

`default_nettype wire
